FILE: sv/rat_pkg.sv
// Shared types and codes of the retransmit/acknowledge tracker.
// Used by rat_rec_store, retransmit_ack_tracker and rat_checker.
`default_nettype none
package rat_pkg;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_REG   = 2'd1;
    localparam logic [1:0] ACT_BCAST = 2'd2;
    localparam logic [1:0] ACT_ACK   = 2'd3;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_DROP = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [1:0] CFG_RESEND   = 2'd0;
    localparam logic [1:0] CFG_MAXFAIL  = 2'd1;
    localparam logic [1:0] CFG_LOCALIP  = 2'd2;
    localparam logic [1:0] CFG_LOCALPRT = 2'd3;

    localparam logic [15:0] RESEND_RESET  = 16'd1000;
    localparam logic [7:0]  MAXFAIL_RESET = 8'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [31:0] ack_sequence;
        logic [7:0]  retry_limit;
        logic        skip_peer;
        logic        reset_fail;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic [31:0] sequence_res;
        logic [1:0]  status;
        logic        last;
    } res_t;

    // One pending record as held in the record memory.
    typedef struct packed {
        logic [31:0] seq;
        logic [7:0]  sent;
        logic [7:0]  limit;
        logic [31:0] last_time;
    } rec_t;

endpackage
`default_nettype wire

FILE: sv/rat_rec_store.sv
// Record memory: one write port, one read port, registered read data.
// Depends on rat_pkg (rec_t).
`default_nettype none
module rat_rec_store
    import rat_pkg::*;
#(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire rec_t          wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output rec_t               rd_data
);

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: sv/retransmit_ack_tracker.sv
// Top level of the retransmit/acknowledge tracker.
// Depends on rat_pkg and rat_rec_store.
`default_nettype none
// One request at a time. Register requests, and acknowledges from an unknown peer,
// go from the execute state straight to the done result. A broadcast visits every
// destination slot in turn. An acknowledge reads the records of the peer one by
// one until the sequence matches, and reports not found when none does. A tick
// walks every destination: each record of a kept destination is read from the
// record memory in S_RREQ and, when resent, written back from S_RPROC, one at a time.
// Records of a destination are found from per-entry valid/destination flops,
// so free and owned entries are located without a memory sweep. Results leave
// through one output register; the walk pauses while it is full and stalled.
// Configuration writes are always ready. No clearing pass after reset.
module retransmit_ack_tracker
    import rat_pkg::*;
#(
    parameter int DEST_COUNT   = 8,
    parameter int RECORD_COUNT = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req_data,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output res_t             rsp_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int DW = (DEST_COUNT > 1) ? $clog2(DEST_COUNT) : 1;
    localparam int RW = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
    localparam logic [DW-1:0] D_LAST = DW'(DEST_COUNT - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_TDEST = 7'b0000100,
        S_RREQ  = 7'b0001000,
        S_RPROC = 7'b0010000,
        S_BCAST = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;

    logic [15:0] resend_reg;
    logic [7:0]  maxfail_reg;
    logic [31:0] lip_reg;
    logic [15:0] lport_reg;

    logic [31:0] now_reg, now_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] seqres_reg, seqres_next;
    logic [1:0]  status_reg, status_next;

    // destination table
    logic [DEST_COUNT-1:0] dvalid_reg, dvalid_next;
    logic [31:0] daddr_reg [DEST_COUNT];
    logic [31:0] daddr_next [DEST_COUNT];
    logic [15:0] dport_reg [DEST_COUNT];
    logic [15:0] dport_next [DEST_COUNT];
    logic [7:0]  dfail_reg [DEST_COUNT];
    logic [7:0]  dfail_next [DEST_COUNT];

    // per-record valid and owner
    logic [RECORD_COUNT-1:0] rvalid_reg, rvalid_next;
    logic [DW-1:0] rdest_reg [RECORD_COUNT];
    logic [DW-1:0] rdest_next [RECORD_COUNT];

    logic [DW-1:0] dcur_reg, dcur_next;
    logic [RW-1:0] rcur_reg, rcur_next;
    logic [RECORD_COUNT-1:0] pend_reg, pend_next;

    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;

    // memory port
    logic    mem_we, mem_re;
    logic [RW-1:0] mem_waddr, mem_raddr;
    rec_t    mem_wdata, mem_rdata;

    rat_rec_store #(.DEPTH(RECORD_COUNT)) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // searches over the flop tables
    logic [DW-1:0] find_idx, dfree_idx;
    logic          find_any, dfree_any;
    logic [RW-1:0] low_idx, rfree_idx;
    logic          low_any, rfree_any;
    logic [RECORD_COUNT-1:0] owned;

    always_comb
    begin
        find_idx  = '0;
        find_any  = 1'b0;
        dfree_idx = '0;
        dfree_any = 1'b0;
        for (int d = DEST_COUNT - 1; d >= 0; d--)
        begin
            if (dvalid_reg[d] && daddr_reg[d] == req_reg.peer_addr
                && dport_reg[d] == req_reg.peer_port)
            begin
                find_idx = DW'(d);
                find_any = 1'b1;
            end
            if (!dvalid_reg[d])
            begin
                dfree_idx = DW'(d);
                dfree_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        low_idx   = '0;
        low_any   = 1'b0;
        rfree_idx = '0;
        rfree_any = 1'b0;
        for (int r = RECORD_COUNT - 1; r >= 0; r--)
        begin
            if (pend_reg[r])
            begin
                low_idx = RW'(r);
                low_any = 1'b1;
            end
            if (!rvalid_reg[r])
            begin
                rfree_idx = RW'(r);
                rfree_any = 1'b1;
            end
        end
    end

    // records owned by the destination under dcur (or the acked peer)
    logic [DW-1:0] own_sel;
    always_comb
    begin
        own_sel = (state_reg == S_EXEC) ? find_idx : dcur_reg;
        for (int r = 0; r < RECORD_COUNT; r++)
        begin
            owned[r] = rvalid_reg[r] && (rdest_reg[r] == own_sel);
        end
    end

    logic ofree;
    assign ofree = !out_valid_reg || !rsp_stall;

    logic [31:0] elapsed;
    assign elapsed = now_reg - mem_rdata.last_time;

    logic bc_ok;
    assign bc_ok = dvalid_reg[dcur_reg]
        && !(daddr_reg[dcur_reg] == lip_reg && dport_reg[dcur_reg] == lport_reg)
        && !(req_reg.skip_peer && daddr_reg[dcur_reg] == req_reg.peer_addr
             && dport_reg[dcur_reg] == req_reg.peer_port);

    logic emit;
    res_t emit_data;

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        now_next    = now_reg;
        seq_next    = seq_reg;
        seqres_next = seqres_reg;
        status_next = status_reg;
        dvalid_next = dvalid_reg;
        daddr_next  = daddr_reg;
        dport_next  = dport_reg;
        dfail_next  = dfail_reg;
        rvalid_next = rvalid_reg;
        rdest_next  = rdest_reg;
        dcur_next   = dcur_reg;
        rcur_next   = rcur_reg;
        pend_next   = pend_reg;
        mem_we      = 1'b0;
        mem_waddr   = rcur_reg;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = low_idx;
        emit        = 1'b0;
        emit_data   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                seqres_next = '0;
                dcur_next   = '0;
                unique case (req_reg.action)
                    ACT_TICK:
                    begin
                        now_next   = now_reg + 32'd1;
                        state_next = S_TDEST;
                    end
                    ACT_REG:
                    begin
                        if (find_any)
                        begin
                            if (req_reg.reset_fail)
                            begin
                                dfail_next[find_idx] = '0;
                            end
                        end
                        else if (dfree_any)
                        begin
                            dvalid_next[dfree_idx] = 1'b1;
                            daddr_next[dfree_idx]  = req_reg.peer_addr;
                            dport_next[dfree_idx]  = req_reg.peer_port;
                            dfail_next[dfree_idx]  = '0;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                        state_next = S_DONE;
                    end
                    ACT_BCAST:
                    begin
                        seqres_next = seq_reg;
                        seq_next    = seq_reg + 32'd1;
                        state_next  = S_BCAST;
                    end
                    ACT_ACK:
                    begin
                        status_next = ST_NOTFOUND;
                        if (find_any)
                        begin
                            dfail_next[find_idx] = '0;
                            dcur_next  = find_idx;
                            pend_next  = owned;
                            state_next = S_RREQ;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_TDEST:
            begin
                if (!dvalid_reg[dcur_reg])
                begin
                    dcur_next  = dcur_reg + DW'(1);
                    state_next = (dcur_reg == D_LAST) ? S_DONE : S_TDEST;
                end
                else if (dfail_reg[dcur_reg] > maxfail_reg)
                begin
                    if (ofree)
                    begin
                        emit = 1'b1;
                        emit_data.kind      = KIND_DROP;
                        emit_data.dest_addr = daddr_reg[dcur_reg];
                        emit_data.dest_port = dport_reg[dcur_reg];
                        dvalid_next[dcur_reg] = 1'b0;
                        rvalid_next = rvalid_reg & ~owned;
                        dcur_next   = dcur_reg + DW'(1);
                        state_next  = (dcur_reg == D_LAST) ? S_DONE : S_TDEST;
                    end
                end
                else
                begin
                    pend_next  = owned;
                    state_next = S_RREQ;
                end
            end
            S_RREQ:
            begin
                if (low_any)
                begin
                    mem_re    = 1'b1;
                    rcur_next = low_idx;
                    pend_next[low_idx] = 1'b0;
                    state_next = S_RPROC;
                end
                else if (req_reg.action == ACT_ACK || dcur_reg == D_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    dcur_next  = dcur_reg + DW'(1);
                    state_next = S_TDEST;
                end
            end
            S_RPROC:
            begin
                if (req_reg.action == ACT_ACK)
                begin
                    if (mem_rdata.seq == req_reg.ack_sequence)
                    begin
                        rvalid_next[rcur_reg] = 1'b0;
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RREQ;
                    end
                end
                else if (mem_rdata.sent == mem_rdata.limit)
                begin
                    // retries used up: free it, one more failure
                    rvalid_next[rcur_reg] = 1'b0;
                    if (dfail_reg[dcur_reg] != 8'hFF)
                    begin
                        dfail_next[dcur_reg] = dfail_reg[dcur_reg] + 8'd1;
                    end
                    state_next = S_RREQ;
                end
                else if (elapsed >= {16'd0, resend_reg})
                begin
                    if (ofree)
                    begin
                        emit = 1'b1;
                        emit_data.kind         = KIND_SEND;
                        emit_data.dest_addr    = daddr_reg[dcur_reg];
                        emit_data.dest_port    = dport_reg[dcur_reg];
                        emit_data.sequence_res = mem_rdata.seq;
                        mem_we = 1'b1;
                        mem_wdata.sent      = mem_rdata.sent + 8'd1;
                        mem_wdata.last_time = now_reg;
                        state_next = S_RREQ;
                    end
                end
                else
                begin
                    state_next = S_RREQ;
                end
            end
            S_BCAST:
            begin
                if (bc_ok)
                begin
                    if (rfree_any)
                    begin
                        rvalid_next[rfree_idx] = 1'b1;
                        rdest_next[rfree_idx]  = dcur_reg;
                        mem_we    = 1'b1;
                        mem_waddr = rfree_idx;
                        mem_wdata.seq       = seqres_reg;
                        mem_wdata.sent      = '0;
                        mem_wdata.limit     = req_reg.retry_limit;
                        mem_wdata.last_time = now_reg - {16'd0, resend_reg};
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                dcur_next  = dcur_reg + DW'(1);
                state_next = (dcur_reg == D_LAST) ? S_DONE : S_BCAST;
            end
            S_DONE:
            begin
                if (ofree)
                begin
                    emit = 1'b1;
                    emit_data.kind         = KIND_DONE;
                    emit_data.sequence_res = seqres_reg;
                    emit_data.status       = status_reg;
                    emit_data.last         = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = emit || (out_valid_reg && rsp_stall);
        out_next       = emit ? emit_data : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            seq_reg       <= '0;
            dvalid_reg    <= '0;
            rvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            resend_reg    <= RESEND_RESET;
            maxfail_reg   <= MAXFAIL_RESET;
            lip_reg       <= '0;
            lport_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            seq_reg       <= seq_next;
            dvalid_reg    <= dvalid_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_RESEND:   resend_reg  <= cfg_data[15:0];
                    CFG_MAXFAIL:  maxfail_reg <= cfg_data[7:0];
                    CFG_LOCALIP:  lip_reg     <= cfg_data;
                    CFG_LOCALPRT: lport_reg   <= cfg_data[15:0];
                    default:      lport_reg   <= lport_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        seqres_reg <= seqres_next;
        status_reg <= status_next;
        daddr_reg  <= daddr_next;
        dport_reg  <= dport_next;
        dfail_reg  <= dfail_next;
        rdest_reg  <= rdest_next;
        dcur_reg   <= dcur_next;
        rcur_reg   <= rcur_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

FILE: sv/rat_checker.sv
// Port-level checks of retransmit_ack_tracker, attached by bind.
// Depends on rat_pkg.
`default_nettype none
module rat_checker
    import rat_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire res_t rsp_data
);

    // one request in flight: taking a request closes the input
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while another is in flight");

    // last marks done and only done
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.last == (rsp_data.kind == KIND_DONE)))
        else $error("last flag does not match result kind");

    // send and drop always report ok
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.kind != KIND_DONE |-> rsp_data.status == ST_OK)
        else $error("non-done result with nonzero status");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

endmodule

bind retransmit_ack_tracker rat_checker u_rat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
`default_nettype wire
